// ----- rtl/hsl_pkg.sv -----
// Shared constants, types and helpers for the HSL to RGB converter.
`default_nettype none

package hsl_pkg;

   // Fixed-point format of saturation, lightness, alpha and color outputs
   localparam int FRAC_BITS = 16;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int UNIT_W    = FRAC_BITS + 1;

   // Hue reduction: one turn is 360 degrees in 1/64 degree units
   localparam int HUE_W       = 24;
   localparam int HUE_TURN    = 360 * 64;
   localparam int HUE_BIAS    = 365 * HUE_TURN;  // lifts any 24-bit hue above zero
   localparam int BIASED_W    = 25;
   localparam int TURN_LOG2   = 9;               // HUE_TURN = 45 * 2^9
   localparam int TURN_RECIP  = 46604;           // ceil(2^21 / 45)
   localparam int TURN_SHIFT  = 21;
   localparam int TURN_W      = 10;
   localparam int REM_W       = 15;
   localparam int SCALE_LOG2  = FRAC_BITS - TURN_LOG2;  // ONE / 2^9
   localparam int FRAC_RECIP  = 2982617;         // ceil(2^27 / 45)
   localparam int FRAC_SHIFT  = 27;

   // Hue ramp breakpoints, truncated
   localparam int SIXTH      = ONE / 6;
   localparam int HALF       = ONE / 2;
   localparam int THIRD      = ONE / 3;
   localparam int TWO_THIRDS = (2 * ONE) / 3;

   // Width of the ramp argument after the one-third offset, signed
   localparam int RAMP_ARG_W = UNIT_W + 1;
   // Width of the interpolation factor, always below ONE
   localparam int FACTOR_W   = FRAC_BITS;

   typedef logic [UNIT_W-1:0] unit_type;

   // Clamp a signed value into 0..ONE
   function automatic unit_type clamp_unit(input logic signed [UNIT_W+1:0] v);
      unit_type r;
      if (v < 0) begin
         r = unit_type'(ONE);
      end else begin
         r = v[UNIT_W-1:0];
      end
      if (v < 0) begin
         r = '0;
      end else if (v > $signed((UNIT_W+2)'(ONE))) begin
         r = unit_type'(ONE);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hsl_req_if.sv -----
// Input channel: one HSL color plus alpha per word.
`default_nettype none

interface hsl_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] hue;
   logic signed [17:0] saturation;
   logic signed [17:0] lightness;
   logic signed [17:0] opacity;

   modport source (output valid, hue, saturation, lightness, opacity, input ready);
   modport sink   (input valid, hue, saturation, lightness, opacity, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsl_rsp_if.sv -----
// Result channel: one RGB color plus alpha per word.
`default_nettype none

interface hsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] red;
   logic [16:0] green;
   logic [16:0] blue;
   logic [16:0] alpha_out;

   modport source (output valid, red, green, blue, alpha_out, input ready);
   modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsl_hue_unit.sv -----
// Hue reduction pipeline: signed angle to turn fraction, four stages.
`default_nettype none

module hsl_hue_unit (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [hsl_pkg::HUE_W-1:0]   hue,
   output      logic [hsl_pkg::FRAC_BITS-1:0]      frac
);

   localparam int PROD1_W = 2 * (hsl_pkg::BIASED_W - hsl_pkg::TURN_LOG2);
   localparam int PROD2_W = 44;

   logic signed [hsl_pkg::BIASED_W:0]   biased;
   logic [hsl_pkg::BIASED_W-1:0]        x_s1_ff, x_s1_in;
   logic [hsl_pkg::BIASED_W-1:0]        x_s2_ff;
   logic [PROD1_W-1:0]                  turn_prod;
   logic [hsl_pkg::TURN_W-1:0]          turn_s2_ff, turn_s2_in;
   logic [hsl_pkg::BIASED_W-1:0]        rem;
   logic [hsl_pkg::REM_W-1:0]           rem_s3_ff, rem_s3_in;
   logic [PROD2_W-1:0]                  frac_prod;
   logic [hsl_pkg::FRAC_BITS-1:0]       frac_s4_ff, frac_s4_in;

   // Stage 1: bias the hue so it is never negative
   always_comb begin
      biased  = (hsl_pkg::BIASED_W+1)'(hue) + (hsl_pkg::BIASED_W+1)'(hsl_pkg::HUE_BIAS);
      x_s1_in = biased[hsl_pkg::BIASED_W-1:0];
   end

   // Stage 2: turn count by reciprocal multiply of the biased hue / 512
   always_comb begin
      turn_prod  = PROD1_W'(x_s1_ff[hsl_pkg::BIASED_W-1:hsl_pkg::TURN_LOG2])
                   * PROD1_W'(hsl_pkg::TURN_RECIP);
      turn_s2_in = turn_prod[hsl_pkg::TURN_SHIFT+hsl_pkg::TURN_W-1:hsl_pkg::TURN_SHIFT];
   end

   // Stage 3: remainder within one turn
   always_comb begin
      rem       = x_s2_ff - hsl_pkg::BIASED_W'(turn_s2_ff)
                  * hsl_pkg::BIASED_W'(hsl_pkg::HUE_TURN);
      rem_s3_in = rem[hsl_pkg::REM_W-1:0];
   end

   // Stage 4: scale remainder to a turn fraction, floor(rem * 128 / 45)
   always_comb begin
      frac_prod  = PROD2_W'({rem_s3_ff, hsl_pkg::SCALE_LOG2'(0)})
                   * PROD2_W'(hsl_pkg::FRAC_RECIP);
      frac_s4_in = frac_prod[hsl_pkg::FRAC_SHIFT+hsl_pkg::FRAC_BITS-1:hsl_pkg::FRAC_SHIFT];
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         x_s1_ff    <= x_s1_in;
         x_s2_ff    <= x_s1_ff;
         turn_s2_ff <= turn_s2_in;
         rem_s3_ff  <= rem_s3_in;
         frac_s4_ff <= frac_s4_in;
      end
   end

   assign frac = frac_s4_ff;

endmodule

`default_nettype wire

// ----- rtl/hsl_qp_unit.sv -----
// Saturation and lightness pipeline: clamp, then form q and p, four stages.
`default_nettype none

module hsl_qp_unit (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [hsl_pkg::UNIT_W:0]      saturation,
   input  wire logic signed [hsl_pkg::UNIT_W:0]      lightness,
   output      hsl_pkg::unit_type                    p_val,
   output      hsl_pkg::unit_type                    q_val
);

   localparam int PROD_W = 2 * hsl_pkg::UNIT_W;

   hsl_pkg::unit_type              s_s1_ff, s_s1_in, l_s1_ff, l_s1_in;
   hsl_pkg::unit_type              s_s2_ff, l_s2_ff, m_s2_ff, m_s2_in;
   logic [PROD_W-1:0]              ls_prod;
   logic signed [hsl_pkg::UNIT_W+1:0] q_raw, p_raw;
   hsl_pkg::unit_type              l_s3_ff, q_s3_ff, q_s3_in;
   hsl_pkg::unit_type              p_s4_ff, p_s4_in, q_s4_ff;
   hsl_pkg::unit_type              p_clamped;

   // Stage 1: clamp inputs to 0..ONE
   always_comb begin
      s_s1_in = hsl_pkg::clamp_unit((hsl_pkg::UNIT_W+2)'(saturation));
      l_s1_in = hsl_pkg::clamp_unit((hsl_pkg::UNIT_W+2)'(lightness));
   end

   // Stage 2: l * s, truncated to the fraction
   always_comb begin
      ls_prod = PROD_W'(l_s1_ff) * PROD_W'(s_s1_ff);
      m_s2_in = ls_prod[hsl_pkg::FRAC_BITS+hsl_pkg::UNIT_W-1:hsl_pkg::FRAC_BITS];
   end

   // Stage 3: q = l*(1+s) below half lightness, else l+s-l*s
   always_comb begin
      if (l_s2_ff < hsl_pkg::UNIT_W'(hsl_pkg::HALF)) begin
         q_raw = $signed((hsl_pkg::UNIT_W+2)'(l_s2_ff)) + $signed((hsl_pkg::UNIT_W+2)'(m_s2_ff));
      end else begin
         q_raw = $signed((hsl_pkg::UNIT_W+2)'(l_s2_ff)) + $signed((hsl_pkg::UNIT_W+2)'(s_s2_ff))
                 - $signed((hsl_pkg::UNIT_W+2)'(m_s2_ff));
      end
      q_s3_in = hsl_pkg::clamp_unit(q_raw);
   end

   // Stage 4: p = 2l - q, clamped and kept at or below q
   always_comb begin
      p_raw     = $signed({1'b0, l_s3_ff, 1'b0}) - $signed((hsl_pkg::UNIT_W+2)'(q_s3_ff));
      p_clamped = hsl_pkg::clamp_unit(p_raw);
      p_s4_in   = (p_clamped > q_s3_ff) ? q_s3_ff : p_clamped;
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         s_s1_ff <= s_s1_in;
         l_s1_ff <= l_s1_in;
         s_s2_ff <= s_s1_ff;
         l_s2_ff <= l_s1_ff;
         m_s2_ff <= m_s2_in;
         l_s3_ff <= l_s2_ff;
         q_s3_ff <= q_s3_in;
         p_s4_ff <= p_s4_in;
         q_s4_ff <= q_s3_ff;
      end
   end

   assign p_val = p_s4_ff;
   assign q_val = q_s4_ff;

endmodule

`default_nettype wire

// ----- rtl/hsl_ramp_unit.sv -----
// Piecewise hue ramp for one color channel, two stages.
`default_nettype none

module hsl_ramp_unit (
   input  wire logic                                    clock,
   input  wire logic                                    en,
   input  wire logic signed [hsl_pkg::RAMP_ARG_W-1:0]   arg,
   input  wire hsl_pkg::unit_type                       p_val,
   input  wire hsl_pkg::unit_type                       q_val,
   output      hsl_pkg::unit_type                       level
);

   localparam int SCALED_W = hsl_pkg::UNIT_W + 3;
   localparam int PROD_W   = hsl_pkg::UNIT_W + hsl_pkg::FACTOR_W;

   logic signed [hsl_pkg::RAMP_ARG_W-1:0] wrapped;
   hsl_pkg::unit_type                      t;
   hsl_pkg::unit_type                      down;
   logic [SCALED_W-1:0]                    scaled;
   logic [hsl_pkg::FACTOR_W-1:0]           factor_ff, factor_in;
   logic                                   use_q_ff, use_q_in;
   hsl_pkg::unit_type                      p_ff, q_ff, d_ff, d_in;
   logic [PROD_W-1:0]                      prod;
   hsl_pkg::unit_type                      level_ff, level_in;

   // Stage 5: wrap the argument, pick the segment and its slope factor
   always_comb begin
      wrapped = arg;
      if (arg < 0) begin
         wrapped = arg + hsl_pkg::RAMP_ARG_W'(hsl_pkg::ONE);
      end else if (arg > $signed(hsl_pkg::RAMP_ARG_W'(hsl_pkg::ONE))) begin
         wrapped = arg - hsl_pkg::RAMP_ARG_W'(hsl_pkg::ONE);
      end
      t        = wrapped[hsl_pkg::UNIT_W-1:0];
      down     = hsl_pkg::UNIT_W'(hsl_pkg::TWO_THIRDS) - t;
      scaled   = '0;
      use_q_in = 1'b0;
      if (t < hsl_pkg::UNIT_W'(hsl_pkg::SIXTH)) begin
         scaled = SCALED_W'(t) * SCALED_W'(6);
      end else if (t < hsl_pkg::UNIT_W'(hsl_pkg::HALF)) begin
         use_q_in = 1'b1;
      end else if (t < hsl_pkg::UNIT_W'(hsl_pkg::TWO_THIRDS)) begin
         scaled = SCALED_W'(down) * SCALED_W'(6);
      end
      factor_in = scaled[hsl_pkg::FACTOR_W-1:0];
      d_in      = q_val - p_val;
   end

   // Stage 6: interpolate between p and q
   always_comb begin
      prod     = PROD_W'(d_ff) * PROD_W'(factor_ff);
      level_in = use_q_ff ? q_ff
                          : p_ff + prod[hsl_pkg::FRAC_BITS+hsl_pkg::UNIT_W-1:hsl_pkg::FRAC_BITS];
   end

   // Advance both stages together
   always_ff @(posedge clock) begin
      if (en) begin
         factor_ff <= factor_in;
         use_q_ff  <= use_q_in;
         p_ff      <= p_val;
         q_ff      <= q_val;
         d_ff      <= d_in;
         level_ff  <= level_in;
      end
   end

   assign level = level_ff;

endmodule

`default_nettype wire

// ----- rtl/hsl_to_rgb_converter.sv -----
// Throughput: one word per cycle; six register stages advance together.
// A stalled output holds the whole pipeline; no word is lost or repeated.
// Stages: hue reduction and q/p forming in four, hue ramp in two.
// Reset clears the stage valid bits only; data registers are not reset.
// Pipeline depth is fixed by the hue unit: two reciprocal multiplies.
`default_nettype none

module hsl_to_rgb_converter (
   input  wire logic  clock,
   input  wire logic  reset,
   hsl_req_if.sink    req_chan,
   hsl_rsp_if.source  rsp_chan
);

   localparam int DEPTH = 6;

   logic                                    stage_en;
   logic [DEPTH-1:0]                        valid_ff, valid_in;
   hsl_pkg::unit_type                       alpha_ff [DEPTH];
   hsl_pkg::unit_type                       alpha_in;
   logic [hsl_pkg::FRAC_BITS-1:0]           frac;
   hsl_pkg::unit_type                       p_val, q_val;
   logic signed [hsl_pkg::RAMP_ARG_W-1:0]   arg_r, arg_g, arg_b;
   hsl_pkg::unit_type                       red_lvl, green_lvl, blue_lvl;

   // Advance the pipeline unless the output word is held
   assign stage_en       = !valid_ff[DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = stage_en;

   // Shift valid bits with the data
   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (stage_en) begin
         valid_ff <= valid_in;
      end
   end

   // Clamp alpha and carry it alongside the color
   assign alpha_in = hsl_pkg::clamp_unit((hsl_pkg::UNIT_W+2)'(req_chan.opacity));

   always_ff @(posedge clock) begin
      if (stage_en) begin
         alpha_ff[0] <= alpha_in;
         for (int i = 1; i < DEPTH; i++) begin
            alpha_ff[i] <= alpha_ff[i-1];
         end
      end
   end

   hsl_hue_unit u_hue (
      .clock (clock),
      .en    (stage_en),
      .hue   (req_chan.hue),
      .frac  (frac)
   );

   hsl_qp_unit u_qp (
      .clock      (clock),
      .en         (stage_en),
      .saturation (req_chan.saturation),
      .lightness  (req_chan.lightness),
      .p_val      (p_val),
      .q_val      (q_val)
   );

   // Offset the hue by a third of a turn for red and blue
   always_comb begin
      arg_g = $signed(hsl_pkg::RAMP_ARG_W'(frac));
      arg_r = arg_g + hsl_pkg::RAMP_ARG_W'(hsl_pkg::THIRD);
      arg_b = arg_g - hsl_pkg::RAMP_ARG_W'(hsl_pkg::THIRD);
   end

   hsl_ramp_unit u_ramp_red (
      .clock (clock), .en (stage_en), .arg (arg_r),
      .p_val (p_val), .q_val (q_val), .level (red_lvl)
   );

   hsl_ramp_unit u_ramp_green (
      .clock (clock), .en (stage_en), .arg (arg_g),
      .p_val (p_val), .q_val (q_val), .level (green_lvl)
   );

   hsl_ramp_unit u_ramp_blue (
      .clock (clock), .en (stage_en), .arg (arg_b),
      .p_val (p_val), .q_val (q_val), .level (blue_lvl)
   );

   // Drive the result word from the last stage
   assign rsp_chan.valid     = valid_ff[DEPTH-1];
   assign rsp_chan.red       = red_lvl;
   assign rsp_chan.green     = green_lvl;
   assign rsp_chan.blue      = blue_lvl;
   assign rsp_chan.alpha_out = alpha_ff[DEPTH-1];

   // A held pipeline keeps every valid bit
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      !stage_en |=> $stable(valid_ff))
      else $error("valid bits moved while pipeline held");

   // An accepted word occupies the first stage next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   // Result components stay within 0..ONE
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.red <= hsl_pkg::UNIT_W'(hsl_pkg::ONE)
                          && rsp_chan.green <= hsl_pkg::UNIT_W'(hsl_pkg::ONE)
                          && rsp_chan.blue <= hsl_pkg::UNIT_W'(hsl_pkg::ONE)
                          && rsp_chan.alpha_out <= hsl_pkg::UNIT_W'(hsl_pkg::ONE)))
      else $error("result component out of range");

   // A taken output word with no word behind it leaves the last stage
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DEPTH-1] && rsp_chan.ready && !valid_ff[DEPTH-2]) |=> !valid_ff[DEPTH-1])
      else $error("output word repeated");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the HSL to RGB color converter.
`timescale 1ns / 1ps

module tb;

   localparam int     FRAC       = 16;
   localparam longint UNIT       = 64'sd1 << FRAC;
   localparam longint TURN       = 64'sd23040;
   localparam longint SIXTH      = UNIT / 6;
   localparam longint HALF       = UNIT / 2;
   localparam longint THIRD      = UNIT / 3;
   localparam longint TWO_THIRDS = (2 * UNIT) / 3;
   localparam int     RANDOM_COLORS = 700;
   localparam int     TAIL_WORDS    = 120;
   localparam int     LONG_HOLD     = 90;
   localparam int     CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic signed [23:0] hue;
      logic signed [17:0] saturation;
      logic signed [17:0] lightness;
      logic signed [17:0] opacity;
   } hsl_word_type;

   typedef struct packed {
      logic [16:0] red;
      logic [16:0] green;
      logic [16:0] blue;
      logic [16:0] alpha_out;
   } rgba_word_type;

   logic clock;
   logic reset;

   hsl_req_if req_chan ();
   hsl_rsp_if rsp_chan ();

   hsl_to_rgb_converter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hsl_word_type  pending_hsl_q[$];
   rgba_word_type expected_rgba_q[$];
   hsl_word_type  cur_offer;
   int            mismatch_count = 0;
   bit            random_phase = 0;
   int            cycle_count = 0;

   // Free-running clock, 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Clamp to the 0..1.0 range of the fixed-point format
   function automatic longint clamp_level(input longint v);
      if (v < 0) begin
         return 0;
      end
      if (v > UNIT) begin
         return UNIT;
      end
      return v;
   endfunction

   // Piecewise hue ramp between p (low) and q (high) at turn fraction t
   function automatic longint hue_ramp(input longint lo, input longint hi, input longint t);
      longint d;
      d = hi - lo;
      if (t < 0) begin
         t = t + UNIT;
      end
      if (t > UNIT) begin
         t = t - UNIT;
      end
      if (t < SIXTH) begin
         return lo + ((d * 6 * t) >> FRAC);
      end
      if (t < HALF) begin
         return hi;
      end
      if (t < TWO_THIRDS) begin
         return lo + ((d * (TWO_THIRDS - t) * 6) >> FRAC);
      end
      return lo;
   endfunction

   // Expected RGBA word for one HSL word
   function automatic rgba_word_type rgba_from_hsl(input hsl_word_type w);
      longint hv, hr, h, s, l, q, p, r, g, b;
      rgba_word_type o;
      hv = $signed(w.hue);
      s  = clamp_level($signed(w.saturation));
      l  = clamp_level($signed(w.lightness));
      hr = hv % TURN;
      if (hr < 0) begin
         hr = hr + TURN;
      end
      h = (hr * UNIT) / TURN;
      if (s == 0) begin
         r = l;
         g = l;
         b = l;
      end else begin
         if (l < HALF) begin
            q = (l * (UNIT + s)) >> FRAC;
         end else begin
            q = l + s - ((l * s) >> FRAC);
         end
         q = clamp_level(q);
         p = clamp_level(2 * l - q);
         if (p > q) begin
            p = q;
         end
         r = hue_ramp(p, q, h + THIRD);
         g = hue_ramp(p, q, h);
         b = hue_ramp(p, q, h - THIRD);
      end
      o.red       = 17'(clamp_level(r));
      o.green     = 17'(clamp_level(g));
      o.blue      = 17'(clamp_level(b));
      o.alpha_out = 17'(clamp_level($signed(w.opacity)));
      return o;
   endfunction

   task automatic queue_color(input longint hue, input longint sat, input longint light,
                              input longint opac);
      hsl_word_type w;
      w.hue        = 24'(hue);
      w.saturation = 18'(sat);
      w.lightness  = 18'(light);
      w.opacity    = 18'(opac);
      pending_hsl_q.push_back(w);
   endtask

   // Mostly in-range levels, with raw bit patterns and the edges mixed in
   function automatic logic signed [17:0] pick_level();
      case ($urandom_range(0, 9))
         0, 1:    return 18'($urandom);
         2:       return '0;
         3:       return 18'(UNIT);
         4:       return 18'($urandom_range(0, 15));
         default: return 18'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic signed [23:0] pick_hue();
      case ($urandom_range(0, 2))
         0:       return 24'($urandom);
         1:       return 24'($urandom_range(0, 23039));
         default: return 24'(longint'($urandom_range(0, 100000)) - 50000);
      endcase
   endfunction

   function automatic bit idle_allowed();
      return !random_phase || (pending_hsl_q.size() > TAIL_WORDS);
   endfunction

   task automatic check_channel(input string label, input logic [16:0] want,
                                input logic [16:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   // Driver: offer pending words, hold until accepted, idle in bursts
   int drv_gap_left = 0;
   int drv_idle_pct = 0;
   int drv_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.hue        <= '0;
         req_chan.saturation <= '0;
         req_chan.lightness  <= '0;
         req_chan.opacity    <= '0;
         drv_gap_left        <= 0;
      end else begin
         drv_cycle <= drv_cycle + 1;
         if (drv_cycle % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       drv_idle_pct <= 0;
               1:       drv_idle_pct <= 12;
               default: drv_idle_pct <= 35;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_rgba_q.push_back(rgba_from_hsl(cur_offer));
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the current word
         end else if (drv_gap_left > 0) begin
            drv_gap_left   <= drv_gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_hsl_q.size() > 0 && idle_allowed() &&
                      $urandom_range(0, 99) < drv_idle_pct) begin
            drv_gap_left   <= $urandom_range(0, 12);
            req_chan.valid <= 1'b0;
         end else if (pending_hsl_q.size() > 0) begin
            cur_offer = pending_hsl_q.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.hue        <= cur_offer.hue;
            req_chan.saturation <= cur_offer.saturation;
            req_chan.lightness  <= cur_offer.lightness;
            req_chan.opacity    <= cur_offer.opacity;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted word, stall the output in bursts
   int mon_hold_left = 0;
   int mon_idle_pct = 0;
   int mon_cycle = 0;
   int words_seen = 0;
   bit long_hold_done = 0;

   always @(posedge clock) begin
      rgba_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         mon_hold_left  <= 0;
      end else begin
         mon_cycle <= mon_cycle + 1;
         if (mon_cycle % 64 == 32) begin
            case ($urandom_range(0, 2))
               0:       mon_idle_pct <= 0;
               1:       mon_idle_pct <= 12;
               default: mon_idle_pct <= 35;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            words_seen <= words_seen + 1;
            if (expected_rgba_q.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected word, expected none, got %0d %0d %0d %0d", $time,
                        rsp_chan.red, rsp_chan.green, rsp_chan.blue, rsp_chan.alpha_out);
            end else begin
               want = expected_rgba_q.pop_front();
               check_channel("red", want.red, rsp_chan.red);
               check_channel("green", want.green, rsp_chan.green);
               check_channel("blue", want.blue, rsp_chan.blue);
               check_channel("alpha_out", want.alpha_out, rsp_chan.alpha_out);
            end
         end
         // Long hold-off once, so the pipeline fills and backs up the input
         if (!long_hold_done && words_seen >= 200) begin
            long_hold_done <= 1'b1;
            mon_hold_left  <= LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else if (mon_hold_left > 0) begin
            mon_hold_left  <= mon_hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_allowed() && $urandom_range(0, 99) < mon_idle_pct) begin
            mon_hold_left  <= $urandom_range(0, 12);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hsl_to_rgb_converter: mismatch");
         $finish;
      end
   end

   // Stimulus and end of test
   initial begin
      hsl_word_type w;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: primaries, ramp breakpoints, hue wrap, clamping, gray
      queue_color(0, UNIT, HALF, UNIT);
      queue_color(7680, UNIT, HALF, 0);
      queue_color(15360, UNIT, HALF, HALF);
      queue_color(3840, UNIT, HALF, UNIT);
      queue_color(11520, UNIT, HALF - 1, 1000);
      queue_color(19200, HALF, HALF, 40000);
      queue_color(-8388608, UNIT, UNIT / 4, 131071);
      queue_color(8388607, THIRD, 3 * UNIT / 4, -131072);
      queue_color(23040, UNIT, HALF, UNIT);
      queue_color(-1, UNIT, HALF, UNIT);
      queue_color(-23040, 20000, 30000, UNIT);
      queue_color(23039, UNIT, HALF, UNIT);
      queue_color(5000, 0, THIRD, UNIT);
      queue_color(5000, -131072, UNIT, UNIT);
      queue_color(9000, 131071, HALF, UNIT + 1);
      queue_color(9000, UNIT, 0, UNIT);
      queue_color(9000, UNIT, UNIT, UNIT);
      queue_color(9000, UNIT, -5, UNIT);
      queue_color(9000, UNIT, 131071, -1);
      queue_color(1000, 1, HALF, UNIT);
      queue_color(7681, UNIT, HALF, UNIT);
      queue_color(0, 0, 0, 0);
      queue_color(-1, -1, -1, -1);
      queue_color(13000, HALF, HALF, UNIT);
      queue_color(17000, 50000, 60000, 65535);

      // Pause the input until every directed word is back
      while (!(pending_hsl_q.size() == 0 && !req_chan.valid &&
               expected_rgba_q.size() == 0)) begin
         @(negedge clock);
      end

      // Random colors
      random_phase = 1'b1;
      for (int i = 0; i < RANDOM_COLORS; i++) begin
         w.hue        = pick_hue();
         w.saturation = pick_level();
         w.lightness  = pick_level();
         w.opacity    = pick_level();
         pending_hsl_q.push_back(w);
      end

      // Drain, then allow for the pipeline depth
      while (!(pending_hsl_q.size() == 0 && !req_chan.valid &&
               expected_rgba_q.size() == 0)) begin
         @(negedge clock);
      end
      repeat (12) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("hsl_to_rgb_converter: match");
      end else begin
         $display("hsl_to_rgb_converter: mismatch");
      end
      $finish;
   end

endmodule
